[sv/ttc_pkg.sv]
// Shared types, constants and microcode for the teletype cursor controller.
// Holds the control word layout, the microprogram and the dispatch table.
// No dependencies.
package ttc_pkg;

  // configuration defaults and register indexes
  localparam int          PAGES_DEFAULT  = 8;
  localparam logic [7:0]  COLUMNS_RESET  = 8'd80;
  localparam logic [7:0]  ROWS_RESET     = 8'd25;
  localparam logic        TEXT_MODE_RESET = 1'b1;
  localparam logic [1:0]  REG_COLUMNS    = 2'd0;
  localparam logic [1:0]  REG_ROWS       = 2'd1;
  localparam logic [1:0]  REG_TEXT_MODE  = 2'd2;

  // character codes
  localparam logic [7:0]  CH_BELL  = 8'd7;
  localparam logic [7:0]  CH_BS    = 8'd8;
  localparam logic [7:0]  CH_TAB   = 8'd9;
  localparam logic [7:0]  CH_LF    = 8'd10;
  localparam logic [7:0]  CH_CR    = 8'd13;
  localparam logic [7:0]  CH_SPACE = 8'd32;

  // scroll fill attributes
  localparam logic [7:0]  FILL_TEXT    = 8'h07;
  localparam logic [7:0]  FILL_GRAPHIC = 8'h00;

  // result limit per item
  localparam int          MAX_RESULTS = 18;
  localparam int          RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // microprogram address width
  localparam int          PC_W = 4;

  typedef enum logic [1:0] {
    KIND_DRAW   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_BEEP   = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BEEP,
    OP_BS,
    OP_CR,
    OP_LF,
    OP_DRAW,
    OP_SPACE,
    OP_WRAP,
    OP_SCROLL,
    OP_CURSOR
  } op_t;

  typedef enum logic [1:0] {
    JMP_SEQ,
    JMP_GOTO,
    JMP_LOOP,
    JMP_END
  } jmp_t;

  typedef struct packed {
    op_t             op;
    jmp_t            jmp;
    logic            last;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic tab_aligned;
  } seq_stat_t;

  // microprogram addresses
  localparam logic [PC_W-1:0] A_BEEP       = 4'd0;
  localparam logic [PC_W-1:0] A_BS         = 4'd1;
  localparam logic [PC_W-1:0] A_CR         = 4'd2;
  localparam logic [PC_W-1:0] A_LF         = 4'd3;
  localparam logic [PC_W-1:0] A_DRAW       = 4'd4;
  localparam logic [PC_W-1:0] A_SPACE      = 4'd5;
  localparam logic [PC_W-1:0] A_TAB_WRAP   = 4'd6;
  localparam logic [PC_W-1:0] A_TAB_SCROLL = 4'd7;
  localparam logic [PC_W-1:0] A_TAB_CURSOR = 4'd8;
  localparam logic [PC_W-1:0] A_WRAP       = 4'd9;
  localparam logic [PC_W-1:0] A_SCROLL     = 4'd10;
  localparam logic [PC_W-1:0] A_CURSOR     = 4'd11;

  // control store
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, jmp: JMP_END, last: 1'b0, target: A_BEEP};
    case (pc)
      A_BEEP:       w = '{op: OP_BEEP,   jmp: JMP_GOTO, last: 1'b0, target: A_WRAP};
      A_BS:         w = '{op: OP_BS,     jmp: JMP_GOTO, last: 1'b0, target: A_WRAP};
      A_CR:         w = '{op: OP_CR,     jmp: JMP_GOTO, last: 1'b0, target: A_WRAP};
      A_LF:         w = '{op: OP_LF,     jmp: JMP_GOTO, last: 1'b0, target: A_WRAP};
      A_DRAW:       w = '{op: OP_DRAW,   jmp: JMP_GOTO, last: 1'b0, target: A_WRAP};
      A_SPACE:      w = '{op: OP_SPACE,  jmp: JMP_SEQ,  last: 1'b0, target: A_SPACE};
      A_TAB_WRAP:   w = '{op: OP_WRAP,   jmp: JMP_SEQ,  last: 1'b0, target: A_SPACE};
      A_TAB_SCROLL: w = '{op: OP_SCROLL, jmp: JMP_SEQ,  last: 1'b0, target: A_SPACE};
      A_TAB_CURSOR: w = '{op: OP_CURSOR, jmp: JMP_LOOP, last: 1'b0, target: A_SPACE};
      A_WRAP:       w = '{op: OP_WRAP,   jmp: JMP_SEQ,  last: 1'b0, target: A_SPACE};
      A_SCROLL:     w = '{op: OP_SCROLL, jmp: JMP_SEQ,  last: 1'b0, target: A_SPACE};
      A_CURSOR:     w = '{op: OP_CURSOR, jmp: JMP_END,  last: 1'b1, target: A_SPACE};
      default:      w = '{op: OP_NONE,   jmp: JMP_END,  last: 1'b0, target: A_BEEP};
    endcase
    return w;
  endfunction

  // entry point chosen by character class
  function automatic logic [PC_W-1:0] dispatch(input logic [7:0] ch);
    logic [PC_W-1:0] a;
    case (ch)
      CH_BELL: a = A_BEEP;
      CH_BS:   a = A_BS;
      CH_CR:   a = A_CR;
      CH_LF:   a = A_LF;
      CH_TAB:  a = A_SPACE;
      default: a = A_DRAW;
    endcase
    return a;
  endfunction

endpackage

[sv/ttc_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on ttc_pkg for the control word and the microprogram.
module ttc_seq
  import ttc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [PC_W-1:0] start_pc,
  input  seq_stat_t       stat,
  output ctrl_t           ctrl,
  output logic            busy
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;

  // current control word
  assign ctrl = ucode_rom(pc);

  // next step selection
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = start_pc;
      busy_next = 1'b1;
    end else if (busy && stat.go) begin
      case (ctrl.jmp)
        JMP_SEQ:  pc_next = pc + 1'b1;
        JMP_GOTO: pc_next = ctrl.target;
        JMP_LOOP: pc_next = stat.tab_aligned ? pc + 1'b1 : ctrl.target;
        JMP_END:  busy_next = 1'b0;
        default:  busy_next = 1'b0;
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

  // start only lands when the sequencer is free or finishing
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    start |-> (!busy || (stat.go && ctrl.jmp == JMP_END)))
    else $error("item started while sequencer still working");

  a_loop_only_at_cursor: assert property (@(posedge clk) disable iff (rst)
    (busy && ctrl.jmp == JMP_LOOP) |-> (ctrl.op == OP_CURSOR))
    else $error("tab loop jump outside cursor step");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && pc == $past(start_pc)))
    else $error("sequencer did not enter the dispatched step");

endmodule

[sv/teletype_cursor_controller.sv]
// Teletype cursor controller: microcoded datapath with per-page cursors.
// First result: from the op step for a draw, bell or tab; after a control step, the
// scroll if one is due, else the cursor set. Steps: op, wrap, scroll, cursor; a tab
// repeats space, wrap, scroll, cursor until aligned, then wrap, scroll, cursor.
// One step per cycle; each step that emits waits while the output register is full.
// Reset (synchronous): cursors of all pages cleared, registers to 80x25 text.
module teletype_cursor_controller
  import ttc_pkg::*;
#(
  parameter int PAGES = PAGES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic [7:0] attribute,
  input  logic       use_attribute,
  input  logic [2:0] page_index,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [2:0] out_page,
  output logic [7:0] cursor_row_out,
  output logic [7:0] cursor_col_out,
  output logic [7:0] glyph,
  output logic [7:0] colour,
  output logic       write_colour,
  output logic       last
);

  localparam int PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  // page_index modulo PAGES by repeated subtraction on a narrow value
  function automatic logic [2:0] page_wrap(input logic [2:0] p);
    logic [3:0] v;
    v = {1'b0, p};
    for (int i = 0; i < 8; i++) begin
      if (v >= 4'(PAGES)) v = v - 4'(PAGES);
    end
    return v[2:0];
  endfunction

  // configuration registers
  logic [7:0] columns;
  logic [7:0] rows;
  logic       text_mode;

  // per-page cursor store
  logic [7:0] cur_row [PAGES];
  logic [7:0] cur_col [PAGES];

  // item registers and working cursor
  logic [7:0]           ch;
  logic [7:0]           attr;
  logic                 ua;
  logic [2:0]           page;
  logic [7:0]           row;
  logic [7:0]           col;
  logic [RES_CNT_W-1:0] res_cnt;

  // control
  ctrl_t      ctrl;
  seq_stat_t  stat;
  logic       busy;
  logic       row_hit, col_hit, need_emit, cap, slot_free;
  logic       fire, emit_now, finish, accept, store;
  logic [2:0] page_in;

  // result fields for the current step
  kind_t      res_kind;
  logic [7:0] res_row, res_col, res_glyph, res_colour;
  logic       res_wc, res_last;

  ttc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .start_pc (dispatch(char_code)),
    .stat     (stat),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  // step control and handshake
  always_comb begin
    row_hit   = (row == rows);
    col_hit   = (col == columns);
    need_emit = (ctrl.op inside {OP_BEEP, OP_DRAW, OP_SPACE, OP_CURSOR}) ||
                (ctrl.op == OP_SCROLL && row_hit);
    cap       = (res_cnt == RES_CNT_W'(MAX_RESULTS));
    slot_free = !out_valid || out_ready;
    stat.go   = !need_emit || cap || slot_free;
    stat.tab_aligned = (col[2:0] == 3'd0);
    fire      = busy && stat.go;
    emit_now  = fire && need_emit && !cap;
    finish    = fire && (ctrl.jmp == JMP_END);
    in_ready  = !busy || finish;
    accept    = in_valid && in_ready;
    store     = fire && (ctrl.op == OP_CURSOR);
    page_in   = page_wrap(page_index);
  end

  // result field selection
  always_comb begin
    res_kind   = KIND_CURSOR;
    res_row    = 8'd0;
    res_col    = 8'd0;
    res_glyph  = 8'd0;
    res_colour = 8'd0;
    res_wc     = 1'b0;
    res_last   = ctrl.last || (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
    case (ctrl.op)
      OP_DRAW, OP_SPACE: begin
        res_kind   = KIND_DRAW;
        res_row    = row;
        res_col    = col;
        res_glyph  = (ctrl.op == OP_SPACE) ? CH_SPACE : ch;
        res_colour = attr;
        res_wc     = ua;
      end
      OP_SCROLL: begin
        res_kind   = KIND_SCROLL;
        res_colour = text_mode ? FILL_TEXT : FILL_GRAPHIC;
      end
      OP_BEEP: begin
        res_kind = KIND_BEEP;
      end
      default: begin
        res_kind = KIND_CURSOR;
        res_row  = row;
        res_col  = col;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= COLUMNS_RESET;
      rows      <= ROWS_RESET;
      text_mode <= TEXT_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS:   columns   <= cfg_data;
        REG_ROWS:      rows      <= cfg_data;
        REG_TEXT_MODE: text_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // cursor store write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGES; i++) begin
        cur_row[i] <= 8'd0;
        cur_col[i] <= 8'd0;
      end
    end else if (store) begin
      cur_row[page[PIDX_W-1:0]] <= row;
      cur_col[page[PIDX_W-1:0]] <= col;
    end
  end

  // item capture and working cursor datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ch   <= char_code;
      attr <= attribute;
      ua   <= use_attribute;
      page <= page_in;
      // same page written back this cycle: take the working cursor
      if (store && page == page_in) begin
        row <= row;
        col <= col;
      end else begin
        row <= cur_row[page_in[PIDX_W-1:0]];
        col <= cur_col[page_in[PIDX_W-1:0]];
      end
    end else if (fire) begin
      case (ctrl.op)
        OP_BS:             if (col != 8'd0) col <= col - 8'd1;
        OP_CR:             col <= 8'd0;
        OP_LF:             row <= row + 8'd1;
        OP_DRAW, OP_SPACE: col <= col + 8'd1;
        OP_WRAP: begin
          if (col_hit) begin
            col <= 8'd0;
            row <= row + 8'd1;
          end
        end
        OP_SCROLL:         if (row_hit) row <= row - 8'd1;
        default: ;
      endcase
    end
  end

  // results emitted for the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (accept) begin
      res_cnt <= '0;
    end else if (emit_now) begin
      res_cnt <= res_cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      kind           <= res_kind;
      out_page       <= page;
      cursor_row_out <= res_row;
      cursor_col_out <= res_col;
      glyph          <= res_glyph;
      colour         <= res_colour;
      write_colour   <= res_wc;
      last           <= res_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count past limit");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (emit_now && ctrl.last) |=> (out_valid && last))
    else $error("final result of item not marked last");

  a_wrap_clears_col: assert property (@(posedge clk) disable iff (rst)
    (fire && ctrl.op == OP_WRAP && col_hit) |=> (col == 8'd0))
    else $error("column not cleared on wrap");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && res_cnt == '0))
    else $error("accepted item not started");

endmodule

[verif/tb.sv]
// Self-checking testbench for teletype_cursor_controller: a cursor predictor
// checks every command against what the block should emit for each character.
// Depends on ttc_pkg and the teletype_cursor_controller RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  // no-acceptance cycles tolerated; the longest quiet stretch is the
  // deliberate output hold-off plus a sender gap and a register pause
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF       = 400;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] page;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] glyph;
    logic [7:0] colour;
    logic       wc;
    logic       last;
  } tty_cmd_t;

  // cursor predictor and queue of commands still owed by the block
  class cursor_board;
    logic [7:0] columns;
    logic [7:0] rows;
    logic       text_mode;
    logic [7:0] cur_row [PAGES_DEFAULT];
    logic [7:0] cur_col [PAGES_DEFAULT];
    tty_cmd_t   step_cmds[$];
    tty_cmd_t   awaited[$];
    int         errors;
    int         checked;
    int         scroll_count;

    function new();
      columns   = COLUMNS_RESET;
      rows      = ROWS_RESET;
      text_mode = TEXT_MODE_RESET;
      foreach (cur_row[p]) begin
        cur_row[p] = '0;
        cur_col[p] = '0;
      end
      errors       = 0;
      checked      = 0;
      scroll_count = 0;
    endfunction

    // commands past the per-character limit are dropped
    function void emit_cmd(input kind_t k, input logic [2:0] pg, input logic [7:0] r,
                           input logic [7:0] c, input logic [7:0] g,
                           input logic [7:0] a, input logic wc);
      tty_cmd_t e;
      if (step_cmds.size() >= MAX_RESULTS) return;
      e.kind   = k;
      e.page   = pg;
      e.row    = r;
      e.col    = c;
      e.glyph  = g;
      e.colour = a;
      e.wc     = wc;
      e.last   = 1'b0;
      step_cmds.push_back(e);
    endfunction

    // one character on one page; a tab recurses once per space
    function void put_glyph(input logic [7:0] ch, input logic [7:0] attr,
                            input logic ua, input logic [2:0] pg);
      logic [7:0] r;
      logic [7:0] c;
      r = cur_row[pg];
      c = cur_col[pg];
      case (ch)
        CH_BELL: emit_cmd(KIND_BEEP, pg, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        CH_BS:   if (c != 8'd0) c = c - 8'd1;
        CH_CR:   c = 8'd0;
        CH_LF:   r = r + 8'd1;
        CH_TAB: begin
          do begin
            put_glyph(CH_SPACE, attr, ua, pg);
            r = cur_row[pg];
            c = cur_col[pg];
          end while (c[2:0] != 3'd0);
        end
        default: begin
          emit_cmd(KIND_DRAW, pg, r, c, ch, attr, ua);
          c = c + 8'd1;
        end
      endcase
      // line wrap, then scroll at the bottom edge
      if (c == columns) begin
        c = 8'd0;
        r = r + 8'd1;
      end
      if (r == rows) begin
        scroll_count++;
        emit_cmd(KIND_SCROLL, pg, 8'd0, 8'd0, 8'd0,
                 text_mode ? FILL_TEXT : FILL_GRAPHIC, 1'b0);
        r = r - 8'd1;
      end
      cur_row[pg] = r;
      cur_col[pg] = c;
      emit_cmd(KIND_CURSOR, pg, r, c, 8'd0, 8'd0, 1'b0);
    endfunction

    function void note_item(input logic [7:0] ch, input logic [7:0] attr,
                            input logic ua, input logic [2:0] pg);
      tty_cmd_t tail;
      step_cmds.delete();
      put_glyph(ch, attr, ua, pg);
      tail = step_cmds.pop_back();
      tail.last = 1'b1;
      step_cmds.push_back(tail);
      foreach (step_cmds[i]) awaited.push_back(step_cmds[i]);
    endfunction

    function void report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void compare_field(input string what, input int got, input int want);
      if (got != want)
        report($sformatf("result %0d %s: got %0d expected %0d", checked, what, got, want));
    endfunction

    function void check_result(input tty_cmd_t got);
      tty_cmd_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d with nothing pending (kind %0d page %0d)",
                         checked, got.kind, got.page));
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("out_page", got.page, want.page);
      compare_field("cursor_row_out", got.row, want.row);
      compare_field("cursor_col_out", got.col, want.col);
      compare_field("glyph", got.glyph, want.glyph);
      compare_field("colour", got.colour, want.colour);
      compare_field("write_colour", got.wc, want.wc);
      compare_field("last", got.last, want.last);
    endfunction
  endclass

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       cfg_we        = 1'b0;
  logic [1:0] cfg_index     = REG_COLUMNS;
  logic [7:0] cfg_data      = '0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] char_code     = '0;
  logic [7:0] attribute     = '0;
  logic       use_attribute = 1'b0;
  logic [2:0] page_index    = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [1:0] kind;
  logic [2:0] out_page;
  logic [7:0] cursor_row_out;
  logic [7:0] cursor_col_out;
  logic [7:0] glyph;
  logic [7:0] colour;
  logic       write_colour;
  logic       last;

  cursor_board board;
  tty_cmd_t    seen;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  logic        steady      = 1'b0;
  logic        squeeze_req = 1'b0;

  teletype_cursor_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .attribute     (attribute),
    .use_attribute (use_attribute),
    .page_index    (page_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .out_page      (out_page),
    .cursor_row_out(cursor_row_out),
    .cursor_col_out(cursor_col_out),
    .glyph         (glyph),
    .colour        (colour),
    .write_colour  (write_colour),
    .last          (last)
  );

  always #2 clk = ~clk;

  // character mix: tab share set per phase, the rest spread over all codes
  function automatic logic [7:0] pick_code(input int tab_pct);
    int         r;
    logic [7:0] code;
    code = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < tab_pct) return CH_TAB;
    r = $urandom_range(0, 99);
    if (r < 45) return code;
    if (r < 62) return 8'(32 + $urandom_range(0, 94));
    if (r < 74) return CH_LF;
    if (r < 82) return CH_CR;
    if (r < 93) return CH_BS;
    return CH_BELL;
  endfunction

  // offer one item, opening a new burst after a random gap when due
  task automatic send_char(input logic [7:0] ch, input logic [7:0] attr,
                           input logic ua, input logic [2:0] pg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_code     <= ch;
    attribute     <= attr;
    use_attribute <= ua;
    page_index    <= pg;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_item(ch, attr, ua, pg);
  endtask

  // stop offering and let every owed command come out
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_screen(input logic [7:0] cols, input logic [7:0] nrows,
                            input logic tm);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= nrows;
    @(posedge clk);
    cfg_index <= REG_TEXT_MODE;
    cfg_data  <= {7'd0, tm};
    @(posedge clk);
    cfg_we <= 1'b0;
    board.columns   = cols;
    board.rows      = nrows;
    board.text_mode = tm;
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] nrows, input logic tm,
                           input int count, input int tab_pct, input logic crowd);
    int         i;
    logic [2:0] pg;
    drain();
    set_screen(cols, nrows, tm);
    steady      = crowd;
    squeeze_req = crowd;
    pg = 3'($urandom_range(0, 7));
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) pg = 3'($urandom_range(0, 7));
      send_char(pick_code(tab_pct), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), pg);
    end
    steady = 1'b0;
  endtask

  // result side: stretches of its own ready patterns, one long hold-off on request
  initial begin : result_sink
    int k;
    int span;
    int mode;
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (k = 0; k < span; k++) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 5 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // check every accepted command
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.kind   = kind_t'(kind);
      seen.page   = out_page;
      seen.row    = cursor_row_out;
      seen.col    = cursor_col_out;
      seen.glyph  = glyph;
      seen.colour = colour;
      seen.wc     = write_colour;
      seen.last   = last;
      board.check_result(seen);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int n;
    int start;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset screen: field extremes and every control code
    send_char(8'd65, 8'hFF, 1'b1, 3'd0);
    send_char(8'd0, 8'h00, 1'b0, 3'd0);
    send_char(8'd255, 8'h5A, 1'b1, 3'd0);
    send_char(CH_BELL, 8'hA5, 1'b1, 3'd0);
    send_char(CH_BS, 8'h00, 1'b0, 3'd0);
    send_char(CH_CR, 8'h00, 1'b0, 3'd0);
    // backspace held at column zero
    send_char(CH_BS, 8'h11, 1'b1, 3'd0);
    send_char(CH_LF, 8'h00, 1'b0, 3'd0);
    // tab from an aligned column draws a full eight spaces
    send_char(CH_TAB, 8'h3C, 1'b1, 3'd0);
    send_char(8'd120, 8'h0F, 1'b0, 3'd0);
    send_char(CH_TAB, 8'hC3, 1'b0, 3'd0);
    send_char(8'd90, 8'h81, 1'b0, 3'd7);
    send_char(CH_LF, 8'h00, 1'b1, 3'd3);
    send_char(CH_TAB, 8'h7E, 1'b1, 3'd3);

    // tiny graphics screen: wrap, scroll on wrap, scroll on line feed, tab into wrap
    drain();
    set_screen(8'd3, 8'd2, 1'b0);
    send_char(8'd97, 8'h12, 1'b1, 3'd5);
    send_char(8'd98, 8'h34, 1'b0, 3'd5);
    send_char(8'd99, 8'h56, 1'b1, 3'd5);
    send_char(8'd100, 8'h78, 1'b1, 3'd5);
    send_char(8'd101, 8'h9A, 1'b0, 3'd5);
    send_char(8'd102, 8'hBC, 1'b1, 3'd5);
    send_char(CH_LF, 8'h00, 1'b0, 3'd5);
    send_char(CH_TAB, 8'hDE, 1'b1, 3'd5);
    send_char(CH_BELL, 8'h00, 1'b0, 3'd5);
    send_char(CH_CR, 8'h00, 1'b0, 3'd5);

    // zero columns: every wrap step at column zero wraps, also after an overflow; tabs on a fresh page
    // reach the wrap with the row at the bottom and hit the command limit
    drain();
    set_screen(8'd0, 8'd1, 1'b1);
    for (i = 0; i < 34; i++)
      send_char(CH_TAB, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 3'd2);
    for (i = 0; i < 12; i++)
      send_char(pick_code(30), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                3'd4);

    // zero rows on a fresh page: a carriage return at row zero scrolls to row 255,
    // then every row advance wraps to zero and scrolls again
    drain();
    set_screen(8'd1, 8'd0, 1'b0);
    start = board.scroll_count;
    send_char(CH_CR, 8'h00, 1'b0, 3'd6);
    n = 0;
    while (board.scroll_count - start < 6 && n < 60) begin
      send_char(pick_code(10), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                3'd6);
      n++;
    end

    // random phases across screen shapes, one with the result side held off
    run_phase(8'd80, 8'd25, 1'b1, 30, 15, 1'b0);
    run_phase(8'd16, 8'd4, 1'b0, 50, 20, 1'b1);
    run_phase(8'd255, 8'd255, 1'b1, 25, 15, 1'b0);
    run_phase(8'd1, 8'd1, 1'b0, 20, 15, 1'b0);
    run_phase(8'd7, 8'd3, 1'b1, 30, 25, 1'b0);
    run_phase(8'd40, 8'd12, 1'b0, 20, 15, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/ttc_pkg.sv
sv/ttc_seq.sv
sv/teletype_cursor_controller.sv
verif/tb.sv
